FILE: rtl/sss_pkg.sv
`default_nettype none

package sss_pkg;

    // Bytes of the window that the suffix tables look at
    localparam int TAIL_BYTES = 10;
    localparam int TAIL_W     = 8 * TAIL_BYTES;

    // Any byte at or above this mark selects the Russian table
    localparam logic [7:0] HIGH_BYTE_MARK = 8'hC0;
    localparam logic [7:0] UPPER_FIRST    = 8'h41;
    localparam logic [7:0] UPPER_LAST     = 8'h5A;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    // Configuration register indexes
    localparam int          CFG_INDEX_W  = 1;
    localparam logic [0:0]  REG_MIN_WORD = 1'd0;
    localparam logic [0:0]  REG_MIN_STEM = 1'd1;
    localparam logic [7:0]  MIN_WORD_RST = 8'd4;
    localparam logic [7:0]  MIN_STEM_RST = 8'd3;

    // Replacement codes
    localparam logic [2:0] APP_NONE = 3'd0;
    localparam logic [2:0] APP_AT   = 3'd1;
    localparam logic [2:0] APP_I    = 3'd2;
    localparam logic [2:0] APP_T    = 3'd3;
    localparam logic [2:0] APP_S    = 3'd4;
    localparam logic [2:0] APP_IZE  = 3'd5;
    localparam logic [2:0] APP_ISE  = 3'd6;

    // Per-word status carried down the pipeline
    typedef struct packed {
        logic high_byte;
        logic overflow;
    } word_flags_t;

    // Suffix entry: tail byte k sits at bits [8k+7:8k], last byte of the word at k = 0
    typedef struct packed {
        logic [3:0]        len;
        logic [2:0]        code;
        logic [TAIL_W-1:0] tail;
    } sfx_t;

    // Bytes that a replacement code adds back
    function automatic logic [1:0] repl_len(logic [2:0] code);
        logic [1:0] n;
        case (code)
            APP_AT:  n = 2'd2;
            APP_I:   n = 2'd1;
            APP_T:   n = 2'd1;
            APP_S:   n = 2'd1;
            APP_IZE: n = 2'd3;
            APP_ISE: n = 2'd3;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    // Cyrillic letters in UTF-8
    localparam logic [15:0] RU_A    = 16'hD0B0;
    localparam logic [15:0] RU_V    = 16'hD0B2;
    localparam logic [15:0] RU_G    = 16'hD0B3;
    localparam logic [15:0] RU_E    = 16'hD0B5;
    localparam logic [15:0] RU_I    = 16'hD0B8;
    localparam logic [15:0] RU_IK   = 16'hD0B9;
    localparam logic [15:0] RU_M    = 16'hD0BC;
    localparam logic [15:0] RU_N    = 16'hD0BD;
    localparam logic [15:0] RU_O    = 16'hD0BE;
    localparam logic [15:0] RU_S    = 16'hD181;
    localparam logic [15:0] RU_T    = 16'hD182;
    localparam logic [15:0] RU_U    = 16'hD183;
    localparam logic [15:0] RU_KH   = 16'hD185;
    localparam logic [15:0] RU_SH   = 16'hD188;
    localparam logic [15:0] RU_Y    = 16'hD18B;
    localparam logic [15:0] RU_SOFT = 16'hD18C;
    localparam logic [15:0] RU_YU   = 16'hD18E;
    localparam logic [15:0] RU_YA   = 16'hD18F;

    localparam int EN_COUNT = 36;
    localparam int RU_COUNT = 52;

    // English suffixes, in priority order
    localparam sfx_t EN_TAB [EN_COUNT] = '{
        '{4'd5, APP_AT,   80'("ation")}, '{4'd5, APP_I,    80'("iness")},
        '{4'd4, APP_NONE, 80'("ness")},  '{4'd4, APP_NONE, 80'("ment")},
        '{4'd4, APP_NONE, 80'("able")},  '{4'd4, APP_NONE, 80'("ible")},
        '{4'd4, APP_T,    80'("tion")},  '{4'd4, APP_S,    80'("sion")},
        '{4'd4, APP_NONE, 80'("ling")},  '{4'd4, APP_NONE, 80'("ally")},
        '{4'd4, APP_IZE,  80'("ized")},  '{4'd4, APP_ISE,  80'("ised")},
        '{4'd4, APP_NONE, 80'("ency")},  '{4'd4, APP_NONE, 80'("ancy")},
        '{4'd4, APP_NONE, 80'("ical")},
        '{4'd3, APP_NONE, 80'("ing")},   '{4'd3, APP_NONE, 80'("ful")},
        '{4'd3, APP_NONE, 80'("ous")},   '{4'd3, APP_NONE, 80'("ive")},
        '{4'd3, APP_NONE, 80'("ity")},   '{4'd3, APP_NONE, 80'("ent")},
        '{4'd3, APP_NONE, 80'("ant")},   '{4'd3, APP_NONE, 80'("ism")},
        '{4'd3, APP_NONE, 80'("ist")},   '{4'd3, APP_NONE, 80'("ize")},
        '{4'd3, APP_NONE, 80'("ate")},   '{4'd3, APP_NONE, 80'("ify")},
        '{4'd2, APP_NONE, 80'("ly")},    '{4'd2, APP_NONE, 80'("er")},
        '{4'd2, APP_NONE, 80'("ed")},    '{4'd2, APP_NONE, 80'("es")},
        '{4'd2, APP_NONE, 80'("al")},    '{4'd2, APP_NONE, 80'("en")},
        '{4'd2, APP_NONE, 80'("an")},    '{4'd2, APP_NONE, 80'("or")},
        '{4'd1, APP_NONE, 80'("s")}
    };

    // Russian suffixes, in priority order
    localparam sfx_t RU_TAB [RU_COUNT] = '{
        '{4'd6,  APP_NONE, 80'({RU_O, RU_G, RU_O})},
        '{4'd6,  APP_NONE, 80'({RU_O, RU_M, RU_U})},
        '{4'd6,  APP_NONE, 80'({RU_E, RU_M, RU_U})},
        '{4'd10, APP_NONE, 80'({RU_A, RU_T, RU_SOFT, RU_S, RU_YA})},
        '{4'd10, APP_NONE, 80'({RU_I, RU_T, RU_SOFT, RU_S, RU_YA})},
        '{4'd10, APP_NONE, 80'({RU_YA, RU_T, RU_SOFT, RU_S, RU_YA})},
        '{4'd10, APP_NONE, 80'({RU_O, RU_T, RU_SOFT, RU_S, RU_YA})},
        '{4'd10, APP_NONE, 80'({RU_U, RU_T, RU_SOFT, RU_S, RU_YA})},
        '{4'd6,  APP_NONE, 80'({RU_A, RU_T, RU_SOFT})},
        '{4'd6,  APP_NONE, 80'({RU_YA, RU_T, RU_SOFT})},
        '{4'd6,  APP_NONE, 80'({RU_I, RU_T, RU_SOFT})},
        '{4'd6,  APP_NONE, 80'({RU_Y, RU_T, RU_SOFT})},
        '{4'd6,  APP_NONE, 80'({RU_O, RU_T, RU_SOFT})},
        '{4'd6,  APP_NONE, 80'({RU_U, RU_T, RU_SOFT})},
        '{4'd8,  APP_NONE, 80'({RU_E, RU_N, RU_I, RU_E})},
        '{4'd8,  APP_NONE, 80'({RU_A, RU_N, RU_I, RU_E})},
        '{4'd8,  APP_NONE, 80'({RU_YA, RU_T, RU_I, RU_E})},
        '{4'd6,  APP_NONE, 80'({RU_T, RU_S, RU_YA})},
        '{4'd8,  APP_NONE, 80'({RU_T, RU_SOFT, RU_S, RU_YA})},
        '{4'd6,  APP_NONE, 80'({RU_E, RU_IK, RU_SH})},
        '{4'd6,  APP_NONE, 80'({RU_A, RU_IK, RU_SH})},
        '{4'd4,  APP_NONE, 80'({RU_O, RU_V})},
        '{4'd4,  APP_NONE, 80'({RU_E, RU_V})},
        '{4'd4,  APP_NONE, 80'({RU_E, RU_IK})},
        '{4'd4,  APP_NONE, 80'({RU_O, RU_IK})},
        '{4'd4,  APP_NONE, 80'({RU_I, RU_IK})},
        '{4'd4,  APP_NONE, 80'({RU_Y, RU_IK})},
        '{4'd4,  APP_NONE, 80'({RU_A, RU_YA})},
        '{4'd4,  APP_NONE, 80'({RU_YA, RU_YA})},
        '{4'd4,  APP_NONE, 80'({RU_O, RU_E})},
        '{4'd4,  APP_NONE, 80'({RU_E, RU_E})},
        '{4'd4,  APP_NONE, 80'({RU_Y, RU_E})},
        '{4'd4,  APP_NONE, 80'({RU_I, RU_E})},
        '{4'd4,  APP_NONE, 80'({RU_A, RU_KH})},
        '{4'd4,  APP_NONE, 80'({RU_YA, RU_KH})},
        '{4'd4,  APP_NONE, 80'({RU_A, RU_M})},
        '{4'd4,  APP_NONE, 80'({RU_YA, RU_M})},
        '{4'd4,  APP_NONE, 80'({RU_O, RU_M})},
        '{4'd4,  APP_NONE, 80'({RU_E, RU_M})},
        '{4'd4,  APP_NONE, 80'({RU_U, RU_YU})},
        '{4'd4,  APP_NONE, 80'({RU_YU, RU_YU})},
        '{4'd6,  APP_NONE, 80'({RU_A, RU_E, RU_T})},
        '{4'd6,  APP_NONE, 80'({RU_YA, RU_E, RU_T})},
        '{4'd2,  APP_NONE, 80'(RU_A)},
        '{4'd2,  APP_NONE, 80'(RU_E)},
        '{4'd2,  APP_NONE, 80'(RU_I)},
        '{4'd2,  APP_NONE, 80'(RU_O)},
        '{4'd2,  APP_NONE, 80'(RU_U)},
        '{4'd2,  APP_NONE, 80'(RU_Y)},
        '{4'd2,  APP_NONE, 80'(RU_SOFT)},
        '{4'd2,  APP_NONE, 80'(RU_YA)},
        '{4'd2,  APP_NONE, 80'(RU_YU)}
    };

endpackage

`default_nettype wire

FILE: rtl/sss_cell.sv
`default_nettype none

// One byte of the tail window; takes its neighbor's byte on every shift
module sss_cell (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift_en,
    input  wire logic       clear,
    input  wire logic [7:0] shift_in,
    output logic      [7:0] byte_q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Drop the byte at word end, otherwise advance on shift
    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = 8'd0;
        end
        else if (shift_en)
        begin
            byte_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_q = byte_reg;

endmodule

`default_nettype wire

FILE: rtl/sss_match.sv
`default_nettype none

// Three-stage suffix matcher: capture word, compare all suffixes, select first hit
module sss_match #(
    parameter int CNT_W = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        word_valid,
    output logic                             word_ready,
    input  wire logic [sss_pkg::TAIL_W-1:0]  word_tail,
    input  wire logic [CNT_W-1:0]            word_count,
    input  wire sss_pkg::word_flags_t        word_flags,
    input  wire logic [7:0]                  min_word,
    input  wire logic [7:0]                  min_stem,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [7:0]                       stem_length,
    output logic [2:0]                       append_code,
    output logic                             russian,
    output logic                             overflow
);

    localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 2;

    // Tail matches, word is long enough, and stem plus replacement is long enough
    function automatic logic entry_hit(
        sss_pkg::sfx_t               e,
        logic [sss_pkg::TAIL_W-1:0]  tail,
        logic [CMP_W-1:0]            cnt,
        logic [CMP_W-1:0]            stem_min
    );
        logic             same;
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        same = 1'b1;
        for (int k = 0; k < sss_pkg::TAIL_BYTES; k++)
        begin
            if ((k < int'(e.len)) && (tail[8*k +: 8] != e.tail[8*k +: 8]))
            begin
                same = 1'b0;
            end
        end
        lhs = cnt + CMP_W'(sss_pkg::repl_len(e.code));
        rhs = stem_min + CMP_W'(e.len);
        return same && (cnt >= CMP_W'(e.len)) && (lhs >= rhs);
    endfunction

    // Stage A: captured word
    logic                         a_valid_reg;
    logic [sss_pkg::TAIL_W-1:0]   a_tail_reg;
    logic [CNT_W-1:0]             a_count_reg;
    sss_pkg::word_flags_t         a_flags_reg;

    // Stage B: hit vectors
    logic                         b_valid_reg;
    logic [sss_pkg::EN_COUNT-1:0] b_en_hit_reg;
    logic [sss_pkg::RU_COUNT-1:0] b_ru_hit_reg;
    logic [sss_pkg::EN_COUNT-1:0] b_en_hit_next;
    logic [sss_pkg::RU_COUNT-1:0] b_ru_hit_next;
    logic                         b_word_ok_reg;
    logic [CNT_W-1:0]             b_count_reg;
    sss_pkg::word_flags_t         b_flags_reg;

    // Stage C: result word
    logic                         c_valid_reg;
    logic [7:0]                   c_stem_reg;
    logic [7:0]                   c_stem_next;
    logic [2:0]                   c_code_reg;
    logic [2:0]                   c_code_next;
    logic                         c_russian_reg;
    logic                         c_overflow_reg;

    logic                         a_load;
    logic                         b_load;
    logic                         c_load;
    logic [CMP_W-1:0]             a_count_ext;
    logic                         sel_hit;
    logic [3:0]                   sel_len;
    logic [2:0]                   sel_code;
    logic [CNT_W-1:0]             kept;

    // Advance each stage when the one below has room
    assign c_load     = b_valid_reg && (!c_valid_reg || result_ready);
    assign b_load     = a_valid_reg && (!b_valid_reg || c_load);
    assign word_ready = !a_valid_reg || b_load;
    assign a_load     = word_valid && word_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (word_ready)
            begin
                a_valid_reg <= word_valid;
            end
            if (!b_valid_reg || c_load)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (!c_valid_reg || result_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Capture the finished word
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_tail_reg  <= word_tail;
            a_count_reg <= word_count;
            a_flags_reg <= word_flags;
        end
    end

    // Compare every suffix of both tables in parallel
    assign a_count_ext = CMP_W'(a_count_reg);

    always_comb
    begin
        for (int i = 0; i < sss_pkg::EN_COUNT; i++)
        begin
            b_en_hit_next[i] = entry_hit(sss_pkg::EN_TAB[i], a_tail_reg, a_count_ext,
                                         CMP_W'(min_stem));
        end
        for (int i = 0; i < sss_pkg::RU_COUNT; i++)
        begin
            b_ru_hit_next[i] = entry_hit(sss_pkg::RU_TAB[i], a_tail_reg, a_count_ext,
                                         CMP_W'(min_stem));
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_en_hit_reg  <= b_en_hit_next;
            b_ru_hit_reg  <= b_ru_hit_next;
            b_word_ok_reg <= (a_count_ext >= CMP_W'(min_word));
            b_count_reg   <= a_count_reg;
            b_flags_reg   <= a_flags_reg;
        end
    end

    // Pick the first hit of the selected table
    always_comb
    begin
        sel_hit  = 1'b0;
        sel_len  = 4'd0;
        sel_code = sss_pkg::APP_NONE;
        if (b_flags_reg.high_byte)
        begin
            for (int i = sss_pkg::RU_COUNT - 1; i >= 0; i--)
            begin
                if (b_ru_hit_reg[i])
                begin
                    sel_hit  = 1'b1;
                    sel_len  = sss_pkg::RU_TAB[i].len;
                    sel_code = sss_pkg::RU_TAB[i].code;
                end
            end
        end
        else
        begin
            for (int i = sss_pkg::EN_COUNT - 1; i >= 0; i--)
            begin
                if (b_en_hit_reg[i])
                begin
                    sel_hit  = 1'b1;
                    sel_len  = sss_pkg::EN_TAB[i].len;
                    sel_code = sss_pkg::EN_TAB[i].code;
                end
            end
        end
    end

    // Strip the suffix when the word qualifies
    always_comb
    begin
        kept        = b_count_reg;
        c_code_next = sss_pkg::APP_NONE;
        if (b_word_ok_reg && sel_hit)
        begin
            kept        = b_count_reg - CNT_W'(sel_len);
            c_code_next = sel_code;
        end
        c_stem_next = 8'(kept);
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_stem_reg     <= c_stem_next;
            c_code_reg     <= c_code_next;
            c_russian_reg  <= b_flags_reg.high_byte;
            c_overflow_reg <= b_flags_reg.overflow;
        end
    end

    assign result_valid = c_valid_reg;
    assign stem_length  = c_stem_reg;
    assign append_code  = c_code_reg;
    assign russian      = c_russian_reg;
    assign overflow     = c_overflow_reg;

endmodule

`default_nettype wire

FILE: rtl/suffix_strip_stemmer.sv
// Throughput: one byte per cycle; the byte window is a shift chain of byte cells.
// Pipeline: the edge that accepts the last byte loads the capture stage, and the result word
// then passes the parallel suffix compare and first-hit select stages, each stage a register.
// A stalled result holds the pipeline; bytes keep flowing until the capture stage is full.
// Reset clears the window, byte count, flags and pipeline, and loads the
// minimum word and stem lengths with 4 and 3.
`default_nettype none

module suffix_strip_stemmer #(
    parameter int MAX_WORD_BYTES = 255,
    parameter int WINDOW_BYTES   = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic [sss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data,
    input  wire logic                            data_valid,
    output logic                                 data_ready,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            last,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic [7:0]                           stem_length,
    output logic [2:0]                           append_code,
    output logic                                 russian,
    output logic                                 overflow
);

    localparam int               CNT_W   = $clog2(MAX_WORD_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WORD_BYTES);

    logic [7:0]                 min_word_reg;
    logic [7:0]                 min_stem_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           count_upd;
    logic                       high_reg;
    logic                       high_next;
    logic                       high_upd;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       ovf_upd;
    logic [7:0]                 lc_byte;
    logic                       byte_accept;
    logic                       word_end;
    logic [7:0]                 win_in [WINDOW_BYTES];
    logic [7:0]                 win_q  [WINDOW_BYTES];
    logic [sss_pkg::TAIL_W-1:0] word_tail;
    sss_pkg::word_flags_t       word_flags;

    assign byte_accept = data_valid && data_ready;
    assign word_end    = byte_accept && last;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_word_reg <= sss_pkg::MIN_WORD_RST;
            min_stem_reg <= sss_pkg::MIN_STEM_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                sss_pkg::REG_MIN_WORD: min_word_reg <= cfg_data;
                sss_pkg::REG_MIN_STEM: min_stem_reg <= cfg_data;
                default:               min_word_reg <= min_word_reg;
            endcase
        end
    end

    // Lowercase ASCII capitals
    always_comb
    begin
        lc_byte = data_byte;
        if ((data_byte >= sss_pkg::UPPER_FIRST) && (data_byte <= sss_pkg::UPPER_LAST))
        begin
            lc_byte = data_byte + sss_pkg::CASE_OFFSET;
        end
    end

    // Window chain: cell 0 takes the new byte, each cell takes its neighbor's
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_BYTES; gi++)
        begin : g_win
            if (gi == 0)
            begin : g_head
                assign win_in[gi] = lc_byte;
            end
            else
            begin : g_body
                assign win_in[gi] = win_q[gi-1];
            end

            sss_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (byte_accept),
                .clear    (word_end),
                .shift_in (win_in[gi]),
                .byte_q   (win_q[gi])
            );
        end

        // The matcher sees the window as it stands after this byte
        for (gi = 0; gi < sss_pkg::TAIL_BYTES; gi++)
        begin : g_tail
            assign word_tail[8*gi +: 8] = win_in[gi];
        end
    endgenerate

    // Saturating count and sticky flags, updated with this byte
    assign count_upd = (count_reg < CNT_MAX) ? (count_reg + CNT_W'(1)) : count_reg;
    assign ovf_upd   = ovf_reg || (count_reg == CNT_MAX);
    assign high_upd  = high_reg || (lc_byte >= sss_pkg::HIGH_BYTE_MARK);

    assign word_flags.high_byte = high_upd;
    assign word_flags.overflow  = ovf_upd;

    always_comb
    begin
        count_next = count_reg;
        high_next  = high_reg;
        ovf_next   = ovf_reg;
        if (word_end)
        begin
            count_next = '0;
            high_next  = 1'b0;
            ovf_next   = 1'b0;
        end
        else if (byte_accept)
        begin
            count_next = count_upd;
            high_next  = high_upd;
            ovf_next   = ovf_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            high_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            high_reg  <= high_next;
            ovf_reg   <= ovf_next;
        end
    end

    sss_match #(
        .CNT_W (CNT_W)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (data_valid && last),
        .word_ready   (data_ready),
        .word_tail    (word_tail),
        .word_count   (count_upd),
        .word_flags   (word_flags),
        .min_word     (min_word_reg),
        .min_stem     (min_stem_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stem_length  (stem_length),
        .append_code  (append_code),
        .russian      (russian),
        .overflow     (overflow)
    );

    // Russian table never carries a replacement
    a_ru_no_append: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && russian |-> append_code == sss_pkg::APP_NONE)
        else $error("russian result carries a replacement code");

    // Count never passes its ceiling
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("byte count above ceiling");

    // Overflow only once the count has saturated
    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == CNT_MAX)
        else $error("overflow flag without saturated count");

    // Word end returns the per-word state to its cleared value
    a_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
        word_end |=> (count_reg == '0) && !high_reg && !ovf_reg)
        else $error("word state not cleared after last byte");

endmodule

`default_nettype wire

FILE: tb/sv/suffix_strip_stemmer_tb.sv
`default_nettype none

module suffix_strip_stemmer_tb;

    localparam int WORD_LEN_MAX = 255;
    localparam int EN_RULES     = 36;
    localparam int RU_RULES     = 52;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 600000;

    // Cyrillic letters in UTF-8, as the suffix tables spell them
    localparam logic [15:0] CY_A    = 16'hD0B0;
    localparam logic [15:0] CY_V    = 16'hD0B2;
    localparam logic [15:0] CY_G    = 16'hD0B3;
    localparam logic [15:0] CY_E    = 16'hD0B5;
    localparam logic [15:0] CY_I    = 16'hD0B8;
    localparam logic [15:0] CY_IK   = 16'hD0B9;
    localparam logic [15:0] CY_M    = 16'hD0BC;
    localparam logic [15:0] CY_N    = 16'hD0BD;
    localparam logic [15:0] CY_O    = 16'hD0BE;
    localparam logic [15:0] CY_S    = 16'hD181;
    localparam logic [15:0] CY_T    = 16'hD182;
    localparam logic [15:0] CY_U    = 16'hD183;
    localparam logic [15:0] CY_KH   = 16'hD185;
    localparam logic [15:0] CY_SH   = 16'hD188;
    localparam logic [15:0] CY_Y    = 16'hD18B;
    localparam logic [15:0] CY_SOFT = 16'hD18C;
    localparam logic [15:0] CY_YU   = 16'hD18E;
    localparam logic [15:0] CY_YA   = 16'hD18F;

    // One suffix rule: last byte of the suffix in tail[7:0]
    typedef struct packed {
        logic [3:0]  len;
        logic [2:0]  code;
        logic [1:0]  add;
        logic [79:0] tail;
    } suffix_rule_t;

    typedef struct {
        logic [7:0] stem_length;
        logic [2:0] append_code;
        logic       russian;
        logic       overflow;
    } stem_result_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_write_en = 1'b0;
    logic [sss_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [7:0]                      cfg_data     = 8'd0;
    logic                            data_valid   = 1'b0;
    logic                            data_ready;
    logic [7:0]                      data_byte    = 8'd0;
    logic                            last         = 1'b0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    logic [7:0]                      stem_length;
    logic [2:0]                      append_code;
    logic                            russian;
    logic                            overflow;

    // Stemmer state as predicted
    logic [79:0] tail_bytes   = '0;
    int          word_len     = 0;
    bit          saw_high     = 1'b0;
    bit          len_overflow = 1'b0;
    logic [7:0]  min_word     = sss_pkg::MIN_WORD_RST;
    logic [7:0]  min_stem     = sss_pkg::MIN_STEM_RST;

    stem_result_t pending_stems [$];
    logic [7:0]   word_bytes [$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    int           hold_cycles = 0;
    bit           steady      = 1'b0;

    suffix_strip_stemmer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stem_length  (stem_length),
        .append_code  (append_code),
        .russian      (russian),
        .overflow     (overflow)
    );

    always #6 clk = ~clk;

    // Look up rule idx of the English or the Cyrillic table, in priority order
    function automatic suffix_rule_t suffix_rule(bit cyr, int idx);
        logic [79:0]  tail;
        logic [2:0]   code;
        suffix_rule_t r;
        tail = '0;
        code = sss_pkg::APP_NONE;
        if (!cyr) begin
            case (idx)
                0:  begin tail = "ation"; code = sss_pkg::APP_AT;  end
                1:  begin tail = "iness"; code = sss_pkg::APP_I;   end
                2:  tail = "ness";
                3:  tail = "ment";
                4:  tail = "able";
                5:  tail = "ible";
                6:  begin tail = "tion";  code = sss_pkg::APP_T;   end
                7:  begin tail = "sion";  code = sss_pkg::APP_S;   end
                8:  tail = "ling";
                9:  tail = "ally";
                10: begin tail = "ized";  code = sss_pkg::APP_IZE; end
                11: begin tail = "ised";  code = sss_pkg::APP_ISE; end
                12: tail = "ency";
                13: tail = "ancy";
                14: tail = "ical";
                15: tail = "ing";
                16: tail = "ful";
                17: tail = "ous";
                18: tail = "ive";
                19: tail = "ity";
                20: tail = "ent";
                21: tail = "ant";
                22: tail = "ism";
                23: tail = "ist";
                24: tail = "ize";
                25: tail = "ate";
                26: tail = "ify";
                27: tail = "ly";
                28: tail = "er";
                29: tail = "ed";
                30: tail = "es";
                31: tail = "al";
                32: tail = "en";
                33: tail = "an";
                34: tail = "or";
                default: tail = "s";
            endcase
        end
        else begin
            case (idx)
                0:  tail = {CY_O, CY_G, CY_O};
                1:  tail = {CY_O, CY_M, CY_U};
                2:  tail = {CY_E, CY_M, CY_U};
                3:  tail = {CY_A, CY_T, CY_SOFT, CY_S, CY_YA};
                4:  tail = {CY_I, CY_T, CY_SOFT, CY_S, CY_YA};
                5:  tail = {CY_YA, CY_T, CY_SOFT, CY_S, CY_YA};
                6:  tail = {CY_O, CY_T, CY_SOFT, CY_S, CY_YA};
                7:  tail = {CY_U, CY_T, CY_SOFT, CY_S, CY_YA};
                8:  tail = {CY_A, CY_T, CY_SOFT};
                9:  tail = {CY_YA, CY_T, CY_SOFT};
                10: tail = {CY_I, CY_T, CY_SOFT};
                11: tail = {CY_Y, CY_T, CY_SOFT};
                12: tail = {CY_O, CY_T, CY_SOFT};
                13: tail = {CY_U, CY_T, CY_SOFT};
                14: tail = {CY_E, CY_N, CY_I, CY_E};
                15: tail = {CY_A, CY_N, CY_I, CY_E};
                16: tail = {CY_YA, CY_T, CY_I, CY_E};
                17: tail = {CY_T, CY_S, CY_YA};
                18: tail = {CY_T, CY_SOFT, CY_S, CY_YA};
                19: tail = {CY_E, CY_IK, CY_SH};
                20: tail = {CY_A, CY_IK, CY_SH};
                21: tail = {CY_O, CY_V};
                22: tail = {CY_E, CY_V};
                23: tail = {CY_E, CY_IK};
                24: tail = {CY_O, CY_IK};
                25: tail = {CY_I, CY_IK};
                26: tail = {CY_Y, CY_IK};
                27: tail = {CY_A, CY_YA};
                28: tail = {CY_YA, CY_YA};
                29: tail = {CY_O, CY_E};
                30: tail = {CY_E, CY_E};
                31: tail = {CY_Y, CY_E};
                32: tail = {CY_I, CY_E};
                33: tail = {CY_A, CY_KH};
                34: tail = {CY_YA, CY_KH};
                35: tail = {CY_A, CY_M};
                36: tail = {CY_YA, CY_M};
                37: tail = {CY_O, CY_M};
                38: tail = {CY_E, CY_M};
                39: tail = {CY_U, CY_YU};
                40: tail = {CY_YU, CY_YU};
                41: tail = {CY_A, CY_E, CY_T};
                42: tail = {CY_YA, CY_E, CY_T};
                43: tail = CY_A;
                44: tail = CY_E;
                45: tail = CY_I;
                46: tail = CY_O;
                47: tail = CY_U;
                48: tail = CY_Y;
                49: tail = CY_SOFT;
                50: tail = CY_YA;
                default: tail = CY_YU;
            endcase
        end
        // suffix bytes are never zero, so the length is the count of used bytes
        r.len = '0;
        for (int k = 0; k < 10; k++)
            if (tail[8*k +: 8] != 8'd0)
                r.len = 4'(k + 1);
        case (code)
            sss_pkg::APP_AT:                         r.add = 2'd2;
            sss_pkg::APP_I, sss_pkg::APP_T,
            sss_pkg::APP_S:                          r.add = 2'd1;
            sss_pkg::APP_IZE, sss_pkg::APP_ISE:      r.add = 2'd3;
            default:                                 r.add = 2'd0;
        endcase
        r.code = code;
        r.tail = tail;
        return r;
    endfunction

    // Advance the predicted word by one accepted byte; queue the stem at word end
    function automatic void predict_byte(logic [7:0] raw, logic fin);
        logic [7:0]   b;
        stem_result_t res;
        suffix_rule_t r;
        int           rest;
        bit           hit;
        bit           ok;
        b = raw;
        if (b >= "A" && b <= "Z")
            b = b + 8'd32;
        if (b >= 8'hC0)
            saw_high = 1'b1;
        tail_bytes = {tail_bytes[71:0], b};
        if (word_len < WORD_LEN_MAX)
            word_len++;
        else
            len_overflow = 1'b1;
        if (fin) begin
            res.stem_length = word_len[7:0];
            res.append_code = sss_pkg::APP_NONE;
            res.russian     = saw_high;
            res.overflow    = len_overflow;
            hit = 1'b0;
            if (word_len >= int'(min_word)) begin
                for (int i = 0; i < (saw_high ? RU_RULES : EN_RULES); i++) begin
                    if (!hit) begin
                        r = suffix_rule(saw_high, i);
                        ok = (word_len >= int'(r.len));
                        for (int k = 0; k < int'(r.len); k++)
                            if (tail_bytes[8*k +: 8] != r.tail[8*k +: 8])
                                ok = 1'b0;
                        rest = word_len - int'(r.len);
                        if (ok && rest + int'(r.add) >= int'(min_stem)) begin
                            hit = 1'b1;
                            res.stem_length = rest[7:0];
                            res.append_code = r.code;
                        end
                    end
                end
            end
            pending_stems.insert(pending_stems.size(), res);
            tail_bytes   = '0;
            word_len     = 0;
            saw_high     = 1'b0;
            len_overflow = 1'b0;
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'd0;
        if (r < 20)
            return 8'd255;
        if (r < 30)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 6));
    endfunction

    // Send one byte and hold it until the stemmer takes it
    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        last       <= fin;
        @(posedge clk);
        while (!data_ready)
            @(posedge clk);
        predict_byte(b, fin);
    endtask

    task automatic send_word();
        for (int i = 0; i < word_bytes.size(); i++)
            send_byte(word_bytes[i], i == word_bytes.size() - 1);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            word_bytes.insert(word_bytes.size(), s[i]);
    endtask

    // Append n random letters, Latin in either case or two-byte Cyrillic
    task automatic push_letters(bit cyr, int n);
        logic [7:0] c;
        int         r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (cyr) begin
                if (r < 50) begin
                    word_bytes.insert(word_bytes.size(), 8'hD0);
                    word_bytes.insert(word_bytes.size(), 8'($urandom_range(8'hB0, 8'hBF)));
                end
                else if (r < 80) begin
                    word_bytes.insert(word_bytes.size(), 8'hD1);
                    word_bytes.insert(word_bytes.size(), 8'($urandom_range(8'h80, 8'h8F)));
                end
                else begin
                    word_bytes.insert(word_bytes.size(), 8'hD0);
                    word_bytes.insert(word_bytes.size(), 8'($urandom_range(8'h90, 8'hAF)));
                end
            end
            else begin
                c = 8'("a") + 8'($urandom_range(0, 25));
                if (r < 25)
                    c = c - 8'd32;
                word_bytes.insert(word_bytes.size(), c);
            end
        end
    endtask

    // Append a table suffix, Latin letters now and then in capitals
    task automatic push_suffix(bit cyr, int idx);
        suffix_rule_t r;
        logic [7:0]   c;
        r = suffix_rule(cyr, idx);
        for (int k = int'(r.len) - 1; k >= 0; k--) begin
            c = r.tail[8*k +: 8];
            if (!cyr && $urandom_range(0, 4) == 0)
                c = c - 8'd32;
            word_bytes.insert(word_bytes.size(), c);
        end
    endtask

    // Drop valid, let every stem arrive, then let the pipeline settle
    task automatic wait_idle();
        data_valid <= 1'b0;
        while (pending_stems.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both length limits; only called while the stemmer is idle
    task automatic set_limits(logic [7:0] word_min, logic [7:0] stem_min);
        cfg_write_en <= 1'b1;
        cfg_index    <= sss_pkg::REG_MIN_WORD;
        cfg_data     <= word_min;
        @(posedge clk);
        cfg_index    <= sss_pkg::REG_MIN_STEM;
        cfg_data     <= stem_min;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        min_word = word_min;
        min_stem = stem_min;
    endtask

    task automatic build_random_word();
        int kind;
        kind = $urandom_range(0, 99);
        word_bytes.delete();
        if (kind < 40) begin
            push_letters(1'b0, $urandom_range(0, 6));
            push_suffix(1'b0, $urandom_range(0, EN_RULES - 1));
        end
        else if (kind < 70) begin
            push_letters(1'b1, $urandom_range(0, 4));
            push_suffix(1'b1, $urandom_range(0, RU_RULES - 1));
        end
        else if (kind < 78) begin
            // Latin stem, Cyrillic ending
            push_letters(1'b0, $urandom_range(1, 4));
            push_suffix(1'b1, $urandom_range(0, RU_RULES - 1));
        end
        else if (kind < 88) begin
            // break one byte of an otherwise good word
            push_letters(1'b0, $urandom_range(0, 5));
            push_suffix(1'b0, $urandom_range(0, EN_RULES - 1));
            word_bytes[$urandom_range(0, word_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else begin
            repeat ($urandom_range(1, 12))
                word_bytes.insert(word_bytes.size(), 8'($urandom_range(0, 255)));
        end
    endtask

    // Reset limits: case folding, byte-value edges, too-short and single-byte words
    task automatic test_reset_limits();
        word_bytes.delete();
        push_text("NATION");
        send_word();
        word_bytes.delete();
        push_text("Z@[s");
        send_word();
        word_bytes = '{8'hFF, 8'hBF};
        send_word();
        word_bytes = '{8'hC0};
        send_word();
        word_bytes = '{8'h00};
        send_word();
    endtask

    // Zero limits: whole word may be a suffix, replacement codes
    task automatic test_short_limits();
        wait_idle();
        set_limits(8'd0, 8'd0);
        word_bytes.delete();
        push_text("s");
        send_word();
        word_bytes = '{8'hD0, 8'hB0};
        send_word();
        word_bytes.delete();
        push_text("ised");
        send_word();
        word_bytes.delete();
        push_text("ized");
        send_word();
        word_bytes.delete();
        push_text("tion");
        send_word();
    endtask

    // Saturating word: the count stops at its ceiling, the suffix comes from the real tail
    task automatic test_long_words();
        wait_idle();
        set_limits(sss_pkg::MIN_WORD_RST, sss_pkg::MIN_STEM_RST);
        word_bytes.delete();
        push_letters(1'b0, 253);
        push_text("ing");
        send_word();
    endtask

    // Random words under random limits, one phase without idling
    task automatic test_random_words();
        int sent;
        for (int phase = 0; phase < 3; phase++) begin
            wait_idle();
            set_limits(pick_limit(), pick_limit());
            steady = (phase == 1);
            sent = 0;
            while (sent < 50) begin
                build_random_word();
                sent += word_bytes.size();
                send_word();
            end
        end
        steady = 1'b0;
    endtask

    // Stall the result side at random
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            result_ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end
        else begin
            result_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25)
                hold_cycles <= pick_gap();
        end
    end

    // Compare each accepted stem with the oldest prediction
    always @(posedge clk) begin : check_stem
        stem_result_t want;
        if (rst_n && result_valid && result_ready) begin
            if (pending_stems.size() == 0) begin
                $error("unexpected result: stem_length %0d append_code %0d",
                       stem_length, append_code);
                mismatches++;
            end
            else begin
                want = pending_stems.pop_front();
                if (stem_length !== want.stem_length) begin
                    $error("stem_length: expected %0d, got %0d", want.stem_length, stem_length);
                    mismatches++;
                end
                if (append_code !== want.append_code) begin
                    $error("append_code: expected %0d, got %0d", want.append_code, append_code);
                    mismatches++;
                end
                if (russian !== want.russian) begin
                    $error("russian: expected %0d, got %0d", want.russian, russian);
                    mismatches++;
                end
                if (overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, overflow);
                    mismatches++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_limits();
        test_short_limits();
        test_long_words();
        test_random_words();
        wait_idle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
